/* hdl/deq_pkg.sv */
// deq_pkg: shared constants, codes and ring index helper for the deque block
// used by deq_if.sv and double_ended_queue_top.sv; depends on nothing

package deq_pkg;

  localparam int unsigned DEPTH  = 32;
  localparam int unsigned AW     = $clog2(DEPTH);
  localparam int unsigned CW     = $clog2(DEPTH + 1);
  localparam int unsigned CMD_W  = 3;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned ST_W   = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_REAR  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_REAR   = 3'd3,
    CMD_QUERY      = 3'd4,
    CMD_DUMP       = 3'd5
  } cmd_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2
  } status_t;

  // position base + off in the ring, off never exceeds DEPTH
  function automatic logic [AW-1:0] ring_pos(input logic [AW-1:0] base,
                                             input logic [CW-1:0] off);
    logic [CW:0] sum;
    sum = (CW+1)'(base) + (CW+1)'(off);
    if (sum >= (CW+1)'(DEPTH)) begin
      sum = sum - (CW+1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

endpackage

/* hdl/deq_if.sv */
// deq_in_if / deq_out_if: valid-ready channels for commands and results
// depends on deq_pkg for field widths

interface deq_in_if;
  logic                                valid;
  logic                                ready;
  logic [deq_pkg::CMD_W-1:0]           command;
  logic signed [deq_pkg::DATA_W-1:0]   value;

  modport source (output valid, command, value, input ready);
  modport sink   (input valid, command, value, output ready);
endinterface

interface deq_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [deq_pkg::DATA_W-1:0]   data;
  logic [deq_pkg::ST_W-1:0]            status;
  logic                                empty_res;
  logic                                last;

  modport source (output valid, data, status, empty_res, last, input ready);
  modport sink   (input valid, data, status, empty_res, last, output ready);
endinterface

/* hdl/deq_ram.sv */
// deq_ram: generic single write port, single read port ram with registered read
// no dependencies

module deq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/double_ended_queue_top.sv */
// double_ended_queue_top: bounded deque of signed words held in a ring ram (deq_ram)
// depends on deq_pkg and the channels in deq_if.sv
// pushes, queries, failed pops, empty dumps and unknown codes answer the cycle after acceptance;
//   pops with data and dumps read through the ram register, then the output register, and block input;
// throughput: 1 item/cycle otherwise, one dump result a cycle, both while out_if.ready is high
// reset: head index and element count clear; the ram keeps its contents, no clear pass

module double_ended_queue_top (
  input  logic       clk,
  input  logic       rst_n,
  deq_in_if.sink     in_if,
  deq_out_if.source  out_if
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_DUMP
  } state_t;

  state_t                          state_r,      state_nxt;
  logic [deq_pkg::AW-1:0]          head_r,       head_nxt;
  logic [deq_pkg::CW-1:0]          count_r,      count_nxt;
  logic [deq_pkg::CW-1:0]          idx_r,        idx_nxt;
  logic                            out_valid_r,  out_valid_nxt;
  logic [deq_pkg::DATA_W-1:0]      out_data_r,   out_data_nxt;
  deq_pkg::status_t                out_status_r, out_status_nxt;
  logic                            out_empty_r,  out_empty_nxt;
  logic                            out_last_r,   out_last_nxt;

  logic                            we;
  logic                            re;
  logic [deq_pkg::AW-1:0]          waddr;
  logic [deq_pkg::AW-1:0]          raddr;
  logic [deq_pkg::DATA_W-1:0]      rdata;
  logic                            out_free;
  logic                            in_ready;
  logic                            full;
  logic                            empty;
  logic                            dump_last;
  logic [deq_pkg::AW-1:0]          head_dec;
  logic [deq_pkg::CW-1:0]          idx_inc;

  deq_ram #(
    .WIDTH (deq_pkg::DATA_W),
    .DEPTH (deq_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (in_if.value),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign out_free  = !out_valid_r || out_if.ready;
  assign in_ready  = (state_r == S_IDLE) && out_free;
  assign full      = (count_r == deq_pkg::CW'(deq_pkg::DEPTH));
  assign empty     = (count_r == '0);
  assign head_dec  = (head_r == '0) ? deq_pkg::AW'(deq_pkg::DEPTH - 1) : head_r - 1'b1;
  assign idx_inc   = idx_r + 1'b1;
  assign dump_last = (idx_inc == count_r);

  assign in_if.ready      = in_ready;
  assign out_if.valid     = out_valid_r;
  assign out_if.data      = out_data_r;
  assign out_if.status    = out_status_r;
  assign out_if.empty_res = out_empty_r;
  assign out_if.last      = out_last_r;

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    out_status_nxt = out_status_r;
    out_empty_nxt  = out_empty_r;
    out_last_nxt   = out_last_r;
    we             = 1'b0;
    re             = 1'b0;
    waddr          = head_r;
    raddr          = head_r;

    if (out_valid_r && out_if.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_if.valid && in_ready) begin
          out_valid_nxt  = 1'b1;
          out_data_nxt   = '0;
          out_status_nxt = deq_pkg::ST_OK;
          out_empty_nxt  = empty;
          out_last_nxt   = 1'b1;
          case (deq_pkg::cmd_t'(in_if.command)) inside
            deq_pkg::CMD_PUSH_FRONT: begin
              if (full) begin
                out_status_nxt = deq_pkg::ST_OVER;
              end else begin
                we            = 1'b1;
                waddr         = head_dec;
                head_nxt      = head_dec;
                count_nxt     = count_r + 1'b1;
                out_empty_nxt = 1'b0;
              end
            end
            deq_pkg::CMD_PUSH_REAR: begin
              if (full) begin
                out_status_nxt = deq_pkg::ST_OVER;
              end else begin
                we            = 1'b1;
                waddr         = deq_pkg::ring_pos(head_r, count_r);
                count_nxt     = count_r + 1'b1;
                out_empty_nxt = 1'b0;
              end
            end
            deq_pkg::CMD_POP_FRONT, deq_pkg::CMD_POP_REAR: begin
              if (empty) begin
                out_status_nxt = deq_pkg::ST_UNDER;
              end else begin
                re            = 1'b1;
                count_nxt     = count_r - 1'b1;
                out_valid_nxt = 1'b0;
                state_nxt     = S_POP;
                if (deq_pkg::cmd_t'(in_if.command) == deq_pkg::CMD_POP_FRONT) begin
                  raddr    = head_r;
                  head_nxt = deq_pkg::ring_pos(head_r, deq_pkg::CW'(1));
                end else begin
                  raddr = deq_pkg::ring_pos(head_r, count_r - 1'b1);
                end
              end
            end
            deq_pkg::CMD_DUMP: begin
              if (!empty) begin
                re            = 1'b1;
                raddr         = head_r;
                idx_nxt       = '0;
                out_valid_nxt = 1'b0;
                state_nxt     = S_DUMP;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_POP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_data_nxt   = rdata;
          out_status_nxt = deq_pkg::ST_OK;
          out_empty_nxt  = empty;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_DUMP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_data_nxt   = rdata;
          out_status_nxt = deq_pkg::ST_OK;
          out_empty_nxt  = 1'b0;
          out_last_nxt   = dump_last;
          if (dump_last) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt = idx_inc;
            re      = 1'b1;
            raddr   = deq_pkg::ring_pos(head_r, idx_inc);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r   <= out_data_nxt;
    out_status_r <= out_status_nxt;
    out_empty_r  <= out_empty_nxt;
    out_last_r   <= out_last_nxt;
  end

endmodule

/* verif/tb_double_ended_queue_top.sv */
`timescale 1ns / 100ps
// tb_double_ended_queue_top: self-checking testbench for the double-ended queue block
// depends on deq_pkg and the deq_in_if / deq_out_if channels from hdl/deq_if.sv

module tb_double_ended_queue_top;

  localparam int unsigned MAX_REPORTS    = 10;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned HOLD_LEN       = 150;
  localparam int unsigned DRAIN_CYCLES   = 20;
  localparam int unsigned PHASE_ITEMS    = 66;
  localparam logic [deq_pkg::CMD_W-1:0] CMD_SPARE_A = 3'd6;
  localparam logic [deq_pkg::CMD_W-1:0] CMD_SPARE_B = 3'd7;
  localparam logic signed [deq_pkg::DATA_W-1:0] WORD_MAX = {1'b0, {(deq_pkg::DATA_W-1){1'b1}}};
  localparam logic signed [deq_pkg::DATA_W-1:0] WORD_MIN = {1'b1, {(deq_pkg::DATA_W-1){1'b0}}};

  typedef struct {
    logic signed [deq_pkg::DATA_W-1:0] data;
    deq_pkg::status_t                  status;
    logic                              empty_res;
    logic                              last;
  } deq_result_t;

  class deq_scoreboard;
    logic signed [deq_pkg::DATA_W-1:0] ring [deq_pkg::DEPTH];
    logic [deq_pkg::AW-1:0]            head;
    int unsigned                       count;
    deq_result_t                       expected_q[$];
    int unsigned              commands, results_checked, dumps, overflows, underflows, bad;

    function new();
      head = '0;
      count = 0;
    endfunction

    function logic [deq_pkg::AW-1:0] slot(int unsigned off);
      return deq_pkg::AW'((int'(head) + off) % deq_pkg::DEPTH);
    endfunction

    function void add(logic signed [deq_pkg::DATA_W-1:0] data, deq_pkg::status_t st,
                      logic last_flag);
      deq_result_t r;
      r.data = data;
      r.status = st;
      r.empty_res = (count == 0);
      r.last = last_flag;
      expected_q.push_back(r);
    endfunction

    // accepted command transaction: update the model and queue its results
    function void note_command(logic [deq_pkg::CMD_W-1:0] cmd,
                               logic signed [deq_pkg::DATA_W-1:0] val);
      logic signed [deq_pkg::DATA_W-1:0] popped;
      deq_pkg::status_t st;
      popped = '0;
      st = deq_pkg::ST_OK;
      commands++;
      case (cmd)
        deq_pkg::CMD_PUSH_FRONT, deq_pkg::CMD_PUSH_REAR: begin
          if (count == deq_pkg::DEPTH) begin
            st = deq_pkg::ST_OVER;
            overflows++;
          end else if (cmd == deq_pkg::CMD_PUSH_FRONT) begin
            head = (head == 0) ? deq_pkg::AW'(deq_pkg::DEPTH - 1) : head - 1'b1;
            ring[head] = val;
            count++;
          end else begin
            ring[slot(count)] = val;
            count++;
          end
        end
        deq_pkg::CMD_POP_FRONT: begin
          if (count == 0) begin
            st = deq_pkg::ST_UNDER;
            underflows++;
          end else begin
            popped = ring[head];
            head = slot(1);
            count--;
          end
        end
        deq_pkg::CMD_POP_REAR: begin
          if (count == 0) begin
            st = deq_pkg::ST_UNDER;
            underflows++;
          end else begin
            popped = ring[slot(count - 1)];
            count--;
          end
        end
        deq_pkg::CMD_DUMP: begin
          dumps++;
          if (count != 0) begin
            for (int i = 0; i < count; i++) begin
              add(ring[slot(i)], deq_pkg::ST_OK, (i + 1 == count));
            end
            return;
          end
        end
        default: ;
      endcase
      add(popped, st, 1'b1);
    endfunction

    // accepted result transaction: compare with the oldest expectation
    function void check_result(logic signed [deq_pkg::DATA_W-1:0] data,
                               logic [deq_pkg::ST_W-1:0] st,
                               logic empty_res, logic last);
      deq_result_t want;
      results_checked++;
      if (expected_q.size() == 0) begin
        bad++;
        if (bad <= MAX_REPORTS) begin
          $display("unexpected result: data %0d status %0d empty %0b last %0b",
                   data, st, empty_res, last);
        end
        return;
      end
      want = expected_q.pop_front();
      if (data !== want.data || st !== want.status || empty_res !== want.empty_res ||
          last !== want.last) begin
        bad++;
        if (bad <= MAX_REPORTS) begin
          $display("result %0d mismatch: expected data %0d status %0d empty %0b last %0b",
                   results_checked, want.data, want.status, want.empty_res, want.last);
          $display("  got data %0d status %0d empty %0b last %0b", data, st, empty_res, last);
        end
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function int unsigned failures();
      return bad + expected_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  deq_in_if  in_chan ();
  deq_out_if out_chan ();

  double_ended_queue_top uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_chan),
    .out_if (out_chan)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  deq_scoreboard sb;
  int unsigned   idle_pct;
  int unsigned   stall_pct;
  int unsigned   hold_seq, hold_seen, hold_left;
  int unsigned   quiet;
  int unsigned   item_total;
  int unsigned   shadow_count;

  initial begin
    rst_n = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.command = '0;
    in_chan.value = '0;
    out_chan.ready = 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    hold_seq = 0;
    hold_seen = 0;
    hold_left = 0;
    quiet = 0;
    item_total = 0;
    shadow_count = 0;
  end

  // result sink: random stalls plus one long hold-off
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_chan.ready <= 1'b0;
    end else if (hold_seen != hold_seq) begin
      hold_seen <= hold_seq;
      hold_left <= HOLD_LEN;
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // monitor and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_chan.valid && out_chan.ready) begin
        sb.check_result(out_chan.data, out_chan.status, out_chan.empty_res, out_chan.last);
      end
      if (in_chan.valid && in_chan.ready) begin
        sb.note_command(in_chan.command, in_chan.value);
      end
      if ((out_chan.valid && out_chan.ready) || (in_chan.valid && in_chan.ready)) begin
        quiet <= 0;
      end else if (quiet == WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                 WATCHDOG_LIMIT, sb.pending());
        $display("tb_double_ended_queue_top failed");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  function automatic logic signed [deq_pkg::DATA_W-1:0] pick_value();
    case ($urandom_range(7))
      0: return WORD_MAX;
      1: return WORD_MIN;
      2: return '0;
      3: return '1;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [deq_pkg::CMD_W-1:0] pick_command();
    int unsigned w;
    w = $urandom_range(99);
    if (w < 22) return deq_pkg::CMD_PUSH_FRONT;
    if (w < 44) return deq_pkg::CMD_PUSH_REAR;
    if (w < 60) return deq_pkg::CMD_POP_FRONT;
    if (w < 76) return deq_pkg::CMD_POP_REAR;
    if (w < 84) return deq_pkg::CMD_QUERY;
    if (w < 92) return deq_pkg::CMD_DUMP;
    if (w < 96) return CMD_SPARE_A;
    return CMD_SPARE_B;
  endfunction

  task automatic send_item(input logic [deq_pkg::CMD_W-1:0] cmd,
                           input logic signed [deq_pkg::DATA_W-1:0] val);
    while ($urandom_range(99) < idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.command <= cmd;
    in_chan.value <= val;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    if (cmd <= deq_pkg::CMD_DUMP) item_total++;
    if ((cmd == deq_pkg::CMD_PUSH_FRONT || cmd == deq_pkg::CMD_PUSH_REAR) &&
        shadow_count < deq_pkg::DEPTH) begin
      shadow_count++;
    end else if ((cmd == deq_pkg::CMD_POP_FRONT || cmd == deq_pkg::CMD_POP_REAR) &&
                 shadow_count > 0) begin
      shadow_count--;
    end
  endtask

  task automatic fill_burst();
    while (shadow_count < deq_pkg::DEPTH) begin
      send_item($urandom_range(1) ? deq_pkg::CMD_PUSH_REAR : deq_pkg::CMD_PUSH_FRONT,
                pick_value());
    end
    repeat ($urandom_range(2, 1)) begin
      send_item($urandom_range(1) ? deq_pkg::CMD_PUSH_REAR : deq_pkg::CMD_PUSH_FRONT,
                pick_value());
    end
    if ($urandom_range(1)) send_item(deq_pkg::CMD_DUMP, pick_value());
  endtask

  task automatic drain_burst();
    while (shadow_count > 0) begin
      send_item($urandom_range(1) ? deq_pkg::CMD_POP_REAR : deq_pkg::CMD_POP_FRONT,
                pick_value());
    end
    repeat ($urandom_range(2, 1)) begin
      send_item($urandom_range(1) ? deq_pkg::CMD_POP_REAR : deq_pkg::CMD_POP_FRONT,
                pick_value());
    end
    send_item(deq_pkg::CMD_QUERY, pick_value());
    if ($urandom_range(1)) send_item(deq_pkg::CMD_DUMP, pick_value());
  endtask

  initial begin
    int unsigned idle_by_phase[4];
    int unsigned stall_by_phase[4];
    int unsigned phase_start;
    int unsigned pick;
    idle_by_phase = '{0, 80, 0, 18};
    stall_by_phase = '{0, 0, 80, 18};
    sb = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty corner cases, spare codes, field extremes, both ends
    send_item(deq_pkg::CMD_QUERY, '0);
    send_item(deq_pkg::CMD_POP_FRONT, WORD_MAX);
    send_item(deq_pkg::CMD_POP_REAR, WORD_MIN);
    send_item(deq_pkg::CMD_DUMP, '1);
    send_item(CMD_SPARE_A, pick_value());
    send_item(CMD_SPARE_B, pick_value());
    send_item(deq_pkg::CMD_PUSH_FRONT, WORD_MAX);
    send_item(deq_pkg::CMD_PUSH_REAR, WORD_MIN);
    send_item(deq_pkg::CMD_PUSH_FRONT, '0);
    send_item(deq_pkg::CMD_PUSH_REAR, '1);
    send_item(deq_pkg::CMD_QUERY, WORD_MIN);
    send_item(deq_pkg::CMD_DUMP, WORD_MAX);
    send_item(deq_pkg::CMD_POP_REAR, '0);
    send_item(deq_pkg::CMD_POP_FRONT, '1);
    send_item(CMD_SPARE_A, '1);
    send_item(deq_pkg::CMD_DUMP, '0);
    send_item(deq_pkg::CMD_POP_FRONT, WORD_MIN);
    send_item(deq_pkg::CMD_POP_REAR, WORD_MAX);
    send_item(deq_pkg::CMD_POP_FRONT, '1);
    send_item(deq_pkg::CMD_DUMP, '1);

    for (int phase = 0; phase < 4; phase++) begin
      idle_pct = idle_by_phase[phase];
      stall_pct <= stall_by_phase[phase];
      phase_start = item_total;
      if (phase == 0) begin
        // long receiver hold while the sender keeps pushing
        hold_seq <= hold_seq + 1;
        fill_burst();
      end
      while (item_total - phase_start < PHASE_ITEMS) begin
        pick = $urandom_range(9);
        if (pick < 3) begin
          fill_burst();
        end else if (pick < 5) begin
          drain_burst();
        end else begin
          repeat (8) send_item(pick_command(), pick_value());
        end
      end
    end
    in_chan.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("ran %0d commands (%0d dumps, %0d overflows, %0d underflows), checked %0d results",
             sb.commands, sb.dumps, sb.overflows, sb.underflows, sb.results_checked);
    $display("random phases: no idling, sender gaps, receiver stalls, both, plus a long hold");
    if (sb.failures() == 0) begin
      $display("tb_double_ended_queue_top passed");
    end else begin
      $display("%0d failures", sb.failures());
      $display("tb_double_ended_queue_top failed");
    end
    $finish;
  end

endmodule
